// ===== hdl/khrq_pkg.sv =====
`default_nettype none
package khrq_pkg;

  localparam int TIME_BITS_DEF = 12;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int POLL_W     = 10;
  localparam int MS_W       = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COMPAT_MODE     = 3'd0,
    CFG_POLL_MS         = 3'd1,
    CFG_REPEAT_DELAY    = 3'd2,
    CFG_REPEAT_INTERVAL = 3'd3,
    CFG_SOUND_LONG      = 3'd4,
    CFG_DISPLAY_LONG    = 3'd5
  } cfg_idx_t;

  localparam logic [POLL_W-1:0] POLL_MS_RST         = POLL_W'(50000 / 1000);
  localparam logic [MS_W-1:0]   REPEAT_DELAY_RST    = MS_W'(400);
  localparam logic [MS_W-1:0]   REPEAT_INTERVAL_RST = MS_W'(120);
  localparam logic [MS_W-1:0]   SOUND_LONG_RST      = MS_W'(900);
  localparam logic [MS_W-1:0]   DISPLAY_LONG_RST    = MS_W'(900);

  // key bit positions in the key vector
  localparam int K_HOME  = 0;
  localparam int K_SOUND = 1;
  localparam int K_DOWN  = 2;
  localparam int K_UP    = 3;
  localparam int K_START = 4;
  localparam int K_LEFT  = 5;
  localparam int NKEYS   = 6;

  localparam logic [7:0] STICK_MID = 8'h80;
  localparam logic [7:0] STICK_MAX = 8'hFF;
  localparam logic [7:0] STICK_MIN = 8'h00;

  typedef struct packed {
    logic home_held;
    logic sound_held;
    logic down_key_held;
    logic up_key_held;
    logic start_held;
    logic left_held;
    logic resync;
  } in_word_t;

  typedef struct packed {
    logic       home_toggle;
    logic [1:0] vol_down_steps;
    logic [1:0] vol_up_steps;
    logic       eq_cycle;
    logic       mute_toggle;
    logic       brightness_cycle;
    logic       stick_active;
    logic [7:0] stick_x;
    logic [7:0] stick_y;
  } out_word_t;

endpackage
`default_nettype wire

// ===== hdl/key_hold_repeat_qualifier_core.sv =====
`default_nettype none
// Key hold / auto-repeat qualifier. Each input word is one poll tick with six
// key levels and a resync flag; each tick yields exactly one result word with
// home, volume step, equalizer, mute and brightness commands plus the virtual
// stick position. Throughput is one word per clock while the output is not
// stalled; logic between the input and output registers updates key history,
// repeat waits and hold timers in the same cycle; out_valid is registered from
// the input register. Configuration must be written through the cfg_ port
// only while idle (not enforced by the block) and takes effect on the next tick.
module key_hold_repeat_qualifier_core #(
  parameter int TIME_BITS = khrq_pkg::TIME_BITS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire khrq_pkg::in_word_t              in_data,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output khrq_pkg::out_word_t                  out_data,
  input  wire                                  cfg_we,
  input  wire [khrq_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire [khrq_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import khrq_pkg::*;

  localparam int SW = ((TIME_BITS > POLL_W) ? TIME_BITS : POLL_W) + 1;
  localparam int CW = (TIME_BITS > MS_W) ? TIME_BITS : MS_W;
  localparam logic [TIME_BITS-1:0] TMAX = '1;

  function automatic logic [TIME_BITS-1:0] tadd(input logic [TIME_BITS-1:0] t,
                                                input logic [POLL_W-1:0] p);
    logic [SW-1:0] s;
    s = SW'(t) + SW'(p);
    return (s > SW'(TMAX)) ? TMAX : s[TIME_BITS-1:0];
  endfunction

  // configuration
  logic              compat_r;
  logic [POLL_W-1:0] poll_r;
  logic [MS_W-1:0]   delay_r, interval_r, sound_long_r, display_long_r;

  // pipeline
  logic      in_v_r;
  in_word_t  in_r;
  logic      advance;

  // tick state
  logic [NKEYS-1:0]     prev_keys_r, prev_keys_nxt;
  logic [MS_W-1:0]      wait_r [2];
  logic [MS_W-1:0]      wait_nxt [2];
  logic [TIME_BITS-1:0] snd_t_r, snd_t_nxt, dsp_t_r, dsp_t_nxt;
  logic                 snd_l_r, snd_l_nxt, dsp_l_r, dsp_l_nxt;
  out_word_t            res;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = in_v_r && !advance;

  always_comb begin
    logic [NKEYS-1:0] keys, prev, pressed;
    logic             start, combo, prev_combo;
    logic [MS_W-1:0]  w;
    logic [MS_W:0]    diff;
    logic             rep;
    logic [1:0]       steps [2];
    int               i;

    keys[K_HOME]  = in_r.home_held;
    keys[K_SOUND] = in_r.sound_held;
    keys[K_DOWN]  = in_r.down_key_held;
    keys[K_UP]    = in_r.up_key_held;
    keys[K_START] = in_r.start_held;
    keys[K_LEFT]  = in_r.left_held;

    prev      = in_r.resync ? keys : prev_keys_r;
    snd_t_nxt = in_r.resync ? '0 : snd_t_r;
    snd_l_nxt = in_r.resync ? 1'b0 : snd_l_r;
    dsp_t_nxt = in_r.resync ? '0 : dsp_t_r;
    dsp_l_nxt = in_r.resync ? 1'b0 : dsp_l_r;

    start      = keys[K_START];
    combo      = start && keys[K_LEFT];
    prev_combo = prev[K_START] && prev[K_LEFT];
    pressed    = keys & ~prev;

    res = '0;
    res.stick_x = STICK_MID;
    res.stick_y = STICK_MID;
    if (!start) begin
      if (keys[K_DOWN] && keys[K_UP]) begin
        res.stick_active = 1'b1;
        res.stick_y      = STICK_MIN;
      end else if (keys[K_DOWN]) begin
        res.stick_active = 1'b1;
        res.stick_x      = STICK_MIN;
      end else if (keys[K_UP]) begin
        res.stick_active = 1'b1;
        res.stick_x      = STICK_MAX;
      end
    end

    res.home_toggle = pressed[K_HOME] && !compat_r;

    // lane 0 down, lane 1 up
    for (i = 0; i < 2; i++) begin
      w = in_r.resync ? '0 : wait_r[i];
      if (pressed[K_DOWN + i]) w = delay_r;
      diff = {1'b0, w} - (MS_W+1)'(poll_r);
      rep  = 1'b0;
      if (start && keys[K_DOWN + i]) begin
        if (diff[MS_W] || (diff == '0)) begin
          rep         = 1'b1;
          wait_nxt[i] = interval_r;
        end else begin
          wait_nxt[i] = diff[MS_W-1:0];
        end
      end else begin
        wait_nxt[i] = '0;
      end
      steps[i] = 2'(start && pressed[K_DOWN + i]) + 2'(rep);
    end
    res.vol_down_steps = steps[0];
    res.vol_up_steps   = steps[1];

    if (pressed[K_SOUND]) begin
      snd_t_nxt = '0;
      snd_l_nxt = 1'b0;
    end
    if (combo && !prev_combo) begin
      dsp_t_nxt = '0;
      dsp_l_nxt = 1'b0;
    end

    if (keys[K_SOUND]) begin
      snd_t_nxt = tadd(snd_t_nxt, poll_r);
      if (!snd_l_nxt && (CW'(snd_t_nxt) >= CW'(sound_long_r))) begin
        res.mute_toggle = 1'b1;
        snd_l_nxt       = 1'b1;
      end
    end
    if (prev[K_SOUND] && !keys[K_SOUND]) begin
      res.eq_cycle = !snd_l_nxt;
      snd_t_nxt    = '0;
      snd_l_nxt    = 1'b0;
    end

    if (combo) begin
      dsp_t_nxt = tadd(dsp_t_nxt, poll_r);
      if (CW'(dsp_t_nxt) >= CW'(display_long_r)) dsp_l_nxt = 1'b1;
    end
    if (prev_combo && !combo) begin
      res.brightness_cycle = !dsp_l_nxt;
      dsp_t_nxt            = '0;
      dsp_l_nxt            = 1'b0;
    end

    prev_keys_nxt = keys;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      compat_r       <= 1'b0;
      poll_r         <= POLL_MS_RST;
      delay_r        <= REPEAT_DELAY_RST;
      interval_r     <= REPEAT_INTERVAL_RST;
      sound_long_r   <= SOUND_LONG_RST;
      display_long_r <= DISPLAY_LONG_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COMPAT_MODE:     compat_r       <= cfg_wdata[0];
        CFG_POLL_MS:         poll_r         <= cfg_wdata[POLL_W-1:0];
        CFG_REPEAT_DELAY:    delay_r        <= cfg_wdata[MS_W-1:0];
        CFG_REPEAT_INTERVAL: interval_r     <= cfg_wdata[MS_W-1:0];
        CFG_SOUND_LONG:      sound_long_r   <= cfg_wdata[MS_W-1:0];
        CFG_DISPLAY_LONG:    display_long_r <= cfg_wdata[MS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r      <= 1'b0;
      out_valid   <= 1'b0;
      prev_keys_r <= '0;
      wait_r[0]   <= '0;
      wait_r[1]   <= '0;
      snd_t_r     <= '0;
      snd_l_r     <= 1'b0;
      dsp_t_r     <= '0;
      dsp_l_r     <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        in_v_r <= 1'b1;
        in_r   <= in_data;
      end else if (advance) begin
        in_v_r <= 1'b0;
      end
      if (advance) begin
        out_valid <= in_v_r;
        if (in_v_r) begin
          out_data    <= res;
          prev_keys_r <= prev_keys_nxt;
          wait_r[0]   <= wait_nxt[0];
          wait_r[1]   <= wait_nxt[1];
          snd_t_r     <= snd_t_nxt;
          snd_l_r     <= snd_l_nxt;
          dsp_t_r     <= dsp_t_nxt;
          dsp_l_r     <= dsp_l_nxt;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== tb/key_hold_repeat_qualifier_core_tb.sv =====
`timescale 1ns / 1ps

module key_hold_repeat_qualifier_core_tb;
  import khrq_pkg::*;

  localparam int TMAX = (1 << TIME_BITS_DEF) - 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  key_hold_repeat_qualifier_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  in_word_t  pending_ticks[$];
  out_word_t expected_cmds[$];
  logic      in_taken = 1'b0;
  int        idle_pct = 38;
  int        errors = 0;
  int        ticks_sent = 0;
  int        results_seen = 0;
  int        settings_used = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;
  logic [NKEYS-1:0] held_lvl = '0;

  // shadow registers and tick state
  bit compat_on;
  int poll_ms_cfg, delay_cfg, interval_cfg, sound_long_cfg, display_long_cfg;
  logic [NKEYS-1:0] last_keys;
  int down_rep_wait, up_rep_wait, sound_ms, display_ms;
  bit sound_long_hit, display_long_hit;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int hold_add(int t);
    int s;
    s = t + poll_ms_cfg;
    return (s > TMAX) ? TMAX : s;
  endfunction

  function automatic logic [1:0] volume_steps(bit start, bit held, bit pressed,
                                              inout int rep_wait);
    logic [1:0] n;
    n = 2'd0;
    if (start && pressed) begin
      n++;
      rep_wait = delay_cfg;
    end
    if (start && held) begin
      rep_wait -= poll_ms_cfg;
      if (rep_wait <= 0) begin
        n++;
        rep_wait = interval_cfg;
      end
    end else begin
      rep_wait = 0;
    end
    return n;
  endfunction

  function automatic out_word_t qualify_tick(in_word_t w);
    logic [NKEYS-1:0] keys, pressed;
    bit start, combo, prev_combo;
    out_word_t r;
    keys[K_HOME]  = w.home_held;
    keys[K_SOUND] = w.sound_held;
    keys[K_DOWN]  = w.down_key_held;
    keys[K_UP]    = w.up_key_held;
    keys[K_START] = w.start_held;
    keys[K_LEFT]  = w.left_held;
    r = '0;
    r.stick_x = STICK_MID;
    r.stick_y = STICK_MID;

    if (w.resync) begin
      last_keys = keys;
      down_rep_wait = 0;
      up_rep_wait = 0;
      sound_ms = 0;
      sound_long_hit = 0;
      display_ms = 0;
      display_long_hit = 0;
    end

    start = keys[K_START];
    combo = start && keys[K_LEFT];
    prev_combo = last_keys[K_START] && last_keys[K_LEFT];
    pressed = keys & ~last_keys;

    if (!start) begin
      if (keys[K_DOWN] && keys[K_UP]) begin
        r.stick_active = 1'b1;
        r.stick_y = STICK_MIN;
      end else if (keys[K_DOWN]) begin
        r.stick_active = 1'b1;
        r.stick_x = STICK_MIN;
      end else if (keys[K_UP]) begin
        r.stick_active = 1'b1;
        r.stick_x = STICK_MAX;
      end
    end

    r.home_toggle = pressed[K_HOME] && !compat_on;
    r.vol_down_steps = volume_steps(start, keys[K_DOWN], pressed[K_DOWN], down_rep_wait);
    r.vol_up_steps = volume_steps(start, keys[K_UP], pressed[K_UP], up_rep_wait);

    if (pressed[K_SOUND]) begin
      sound_ms = 0;
      sound_long_hit = 0;
    end
    if (combo && !prev_combo) begin
      display_ms = 0;
      display_long_hit = 0;
    end

    if (keys[K_SOUND]) begin
      sound_ms = hold_add(sound_ms);
      if (!sound_long_hit && sound_ms >= sound_long_cfg) begin
        r.mute_toggle = 1'b1;
        sound_long_hit = 1;
      end
    end
    if (last_keys[K_SOUND] && !keys[K_SOUND]) begin
      r.eq_cycle = !sound_long_hit;
      sound_ms = 0;
      sound_long_hit = 0;
    end

    if (combo) begin
      display_ms = hold_add(display_ms);
      if (!display_long_hit && display_ms >= display_long_cfg)
        display_long_hit = 1;
    end
    if (prev_combo && !combo) begin
      r.brightness_cycle = !display_long_hit;
      display_ms = 0;
      display_long_hit = 0;
    end

    last_keys = keys;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("MISMATCH result %0d %s: got %0d want %0d", results_seen, what, got, want);
  endtask

  task automatic check_field(string what, int got, int want);
    if (got != want)
      report_mismatch(what, got, want);
  endtask

  // sender: offer the next word unless idling; hold a stalled word unchanged
  always @(negedge clk) begin
    logic nxt_valid;
    in_word_t nxt_data;
    nxt_valid = in_valid;
    nxt_data = in_data;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else begin
      if (in_valid && in_taken)
        nxt_valid = 1'b0;
      if (!nxt_valid && pending_ticks.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt_data = pending_ticks.pop_front();
        nxt_valid = 1'b1;
      end
    end
    in_valid <= nxt_valid;
    in_data <= nxt_data;
  end

  // receiver: random stalls plus one long hold-off to back the block up
  always @(negedge clk) begin
    if (!hold_done && results_seen >= 300) begin
      hold_done = 1'b1;
      hold_left = 150;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      expected_cmds.push_back(qualify_tick(in_data));
      ticks_sent++;
    end
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_cmds.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        want = expected_cmds.pop_front();
        check_field("home_toggle", out_data.home_toggle, want.home_toggle);
        check_field("vol_down_steps", out_data.vol_down_steps, want.vol_down_steps);
        check_field("vol_up_steps", out_data.vol_up_steps, want.vol_up_steps);
        check_field("eq_cycle", out_data.eq_cycle, want.eq_cycle);
        check_field("mute_toggle", out_data.mute_toggle, want.mute_toggle);
        check_field("brightness_cycle", out_data.brightness_cycle, want.brightness_cycle);
        check_field("stick_active", out_data.stick_active, want.stick_active);
        check_field("stick_x", out_data.stick_x, want.stick_x);
        check_field("stick_y", out_data.stick_y, want.stick_y);
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_COMPAT_MODE:     compat_on = val[0];
      CFG_POLL_MS:         poll_ms_cfg = int'(val[POLL_W-1:0]);
      CFG_REPEAT_DELAY:    delay_cfg = int'(val[MS_W-1:0]);
      CFG_REPEAT_INTERVAL: interval_cfg = int'(val[MS_W-1:0]);
      CFG_SOUND_LONG:      sound_long_cfg = int'(val[MS_W-1:0]);
      CFG_DISPLAY_LONG:    display_long_cfg = int'(val[MS_W-1:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(int compat, int poll, int dly, int intv, int snd, int disp);
    write_reg(CFG_COMPAT_MODE, CFG_DATA_W'(compat));
    write_reg(CFG_POLL_MS, CFG_DATA_W'(poll));
    write_reg(CFG_REPEAT_DELAY, CFG_DATA_W'(dly));
    write_reg(CFG_REPEAT_INTERVAL, CFG_DATA_W'(intv));
    write_reg(CFG_SOUND_LONG, CFG_DATA_W'(snd));
    write_reg(CFG_DISPLAY_LONG, CFG_DATA_W'(disp));
    settings_used++;
  endtask

  task automatic push_keys(bit home, bit sound, bit down, bit up, bit start, bit left,
                           bit resync = 1'b0);
    in_word_t w;
    w.home_held = home;
    w.sound_held = sound;
    w.down_key_held = down;
    w.up_key_held = up;
    w.start_held = start;
    w.left_held = left;
    w.resync = resync;
    pending_ticks.push_back(w);
  endtask

  // mostly held levels that change one key at a time, some pure noise words
  task automatic queue_ticks(int n);
    logic [$bits(in_word_t)-1:0] noise;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 10) begin
        noise = $urandom;
        pending_ticks.push_back(in_word_t'(noise));
      end else begin
        if ($urandom_range(99) < 15)
          held_lvl[$urandom_range(NKEYS-1)] ^= 1'b1;
        push_keys(held_lvl[K_HOME], held_lvl[K_SOUND], held_lvl[K_DOWN], held_lvl[K_UP],
                  held_lvl[K_START], held_lvl[K_LEFT], $urandom_range(99) < 3);
      end
    end
  endtask

  task automatic wait_idle();
    int spins;
    spins = 0;
    while ((pending_ticks.size() != 0 || in_valid || expected_cmds.size() != 0)
           && spins < 5000) begin
      @(negedge clk);
      spins++;
    end
    if (expected_cmds.size() != 0) begin
      report_mismatch("missing result words", 0, expected_cmds.size());
      expected_cmds.delete();
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic run_ticks(int n);
    queue_ticks(n);
    wait_idle();
  endtask

  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    compat_on = 0;
    poll_ms_cfg = int'(POLL_MS_RST);
    delay_cfg = int'(REPEAT_DELAY_RST);
    interval_cfg = int'(REPEAT_INTERVAL_RST);
    sound_long_cfg = int'(SOUND_LONG_RST);
    display_long_cfg = int'(DISPLAY_LONG_RST);
    last_keys = '0;
    down_rep_wait = 0;
    up_rep_wait = 0;
    sound_ms = 0;
    display_ms = 0;
    sound_long_hit = 0;
    display_long_hit = 0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // directed edges under reset settings
    push_keys(0, 0, 0, 0, 0, 0);
    push_keys(1, 0, 0, 0, 0, 0);
    push_keys(1, 0, 0, 0, 0, 0);
    push_keys(0, 0, 0, 0, 0, 0);
    push_keys(0, 0, 0, 0, 1, 0);
    push_keys(0, 0, 1, 0, 1, 0);
    push_keys(0, 0, 1, 0, 1, 0);
    push_keys(0, 0, 1, 0, 1, 0);
    push_keys(0, 0, 1, 1, 1, 0);
    push_keys(0, 0, 1, 1, 0, 0);
    push_keys(0, 0, 1, 0, 0, 0);
    push_keys(0, 0, 0, 1, 0, 0);
    push_keys(0, 0, 0, 1, 1, 0);  // start after volume key: immediate step
    push_keys(0, 1, 0, 0, 0, 0);
    push_keys(0, 0, 0, 0, 0, 0);
    push_keys(0, 0, 0, 0, 1, 1);
    push_keys(0, 0, 0, 0, 1, 0);
    push_keys(0, 1, 0, 0, 0, 0);
    push_keys(0, 0, 0, 0, 0, 0, 1);  // resync hides the sound release
    push_keys(1, 1, 1, 1, 1, 1, 1);
    push_keys(1, 1, 1, 1, 1, 1, 0);
    push_keys(0, 0, 0, 0, 0, 0, 0);
    wait_idle();

    set_regs(1, 50, 400, 120, 900, 900);
    run_ticks(100);

    idle_pct = 0;
    set_regs(0, 1000, 4095, 4095, 4095, 4095);  // timers saturate
    run_ticks(100);
    idle_pct = 38;

    set_regs(0, 1, 1, 1, 1, 1);
    run_ticks(100);

    set_regs(0, 0, 0, 0, 0, 0);
    write_reg(CFG_SPARE_LO, '1);
    write_reg(CFG_SPARE_HI, 12'h5A5);
    run_ticks(60);

    set_regs(0, 100, 80, 30, 300, 250);  // delay below poll: double step
    run_ticks(100);

    repeat (3) begin
      set_regs($urandom_range(1), $urandom_range(1000, 1), $urandom_range(4095, 1),
               $urandom_range(4095, 1), $urandom_range(4095, 1), $urandom_range(4095, 1));
      run_ticks(70);
    end

    set_regs(0, POLL_MS_RST, REPEAT_DELAY_RST, REPEAT_INTERVAL_RST, SOUND_LONG_RST,
             DISPLAY_LONG_RST);
    run_ticks(80);

    $display("Ran %0d tick words across %0d register settings, %0d result words compared.",
             ticks_sent, settings_used, results_seen);
    $display("Included a %0d-cycle output hold-off and a no-idle stretch; %0d mismatches.",
             150, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
